// ===== rtl/core/ppft_pkg.sv =====
// Shared types, register codes and constants of the pinhole projection and frustum test.
// Used by every module and interface of the block; depends on nothing.
package ppft_pkg;

    localparam int COORD_W = 32;
    localparam int CFG_W   = 22;
    localparam int SIZE_W  = 15;
    localparam int PIX_W   = 24;
    localparam int Z_W     = 31;
    localparam int QUO_W   = 25;
    localparam int PROD_W  = 55;
    localparam int MAG_W   = 54;
    localparam int Q_W     = 27;
    localparam int U_W     = 28;
    localparam int LIM_W   = 25;
    localparam int CMP_W   = 29;
    localparam int CIDX_W  = 3;
    localparam int FRAC_W  = 8;

    typedef enum logic [CIDX_W-1:0] {
        REG_FOCAL_X       = 3'd0,
        REG_FOCAL_Y       = 3'd1,
        REG_CENTER_X      = 3'd2,
        REG_CENTER_Y      = 3'd3,
        REG_IMAGE_WIDTH   = 3'd4,
        REG_IMAGE_HEIGHT  = 3'd5,
        REG_BORDER_MARGIN = 3'd6
    } cfg_reg_t;

    localparam logic signed [PIX_W-1:0] PIX_MAX = 24'sh7FFFFF;
    localparam logic signed [PIX_W-1:0] PIX_MIN = 24'sh800000;

    typedef struct packed {
        logic [CFG_W-1:0]  focal_x;
        logic [CFG_W-1:0]  focal_y;
        logic [CFG_W-1:0]  center_x;
        logic [CFG_W-1:0]  center_y;
        logic [SIZE_W-1:0] image_width;
        logic [SIZE_W-1:0] image_height;
        logic [CFG_W-1:0]  border_margin;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        focal_x:       22'd128000,
        focal_y:       22'd128000,
        center_x:      22'd81920,
        center_y:      22'd61440,
        image_width:   15'd640,
        image_height:  15'd480,
        border_margin: 22'd0
    };

    // One axis of the division: sign of the product, quotient overflow,
    // partial remainder and the combined dividend/quotient shift register.
    typedef struct packed {
        logic             neg;
        logic             ovf;
        logic [Z_W-1:0]   rem;
        logic [QUO_W-1:0] acc;
    } lane_t;

    typedef struct packed {
        logic           valid;
        logic           behind;
        logic [Z_W-1:0] div;
        lane_t          u;
        lane_t          v;
    } cell_t;

    typedef struct packed {
        logic signed [PIX_W-1:0] pixel_u;
        logic signed [PIX_W-1:0] pixel_v;
        logic                    in_view;
        logic                    behind;
        logic                    clipped;
    } result_t;

endpackage

// ===== rtl/core/ppft_point_if.sv =====
// Input channel carrying one camera-frame point per transaction.
// Depends on ppft_pkg for the coordinate width.
interface ppft_point_if import ppft_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;

    modport source (output valid, output point_x, output point_y, output point_z,
                    input ready);
    modport sink (input valid, input point_x, input point_y, input point_z,
                  output ready);
endinterface

// ===== rtl/core/ppft_pixel_if.sv =====
// Output channel carrying one projected pixel and its flags per transaction.
// Depends on ppft_pkg for the pixel width.
interface ppft_pixel_if import ppft_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic signed [PIX_W-1:0] pixel_u;
    logic signed [PIX_W-1:0] pixel_v;
    logic                    in_view;
    logic                    behind;
    logic                    clipped;

    modport source (output valid, output pixel_u, output pixel_v, output in_view,
                    output behind, output clipped, input ready);
    modport sink (input valid, input pixel_u, input pixel_v, input in_view,
                  input behind, input clipped, output ready);
endinterface

// ===== rtl/core/ppft_front.sv =====
// Front end: focal multiply, magnitude and overflow pre-check feeding the divider chain.
// Depends on ppft_pkg.
module ppft_front import ppft_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic signed [COORD_W-1:0] point_x,
    input  logic signed [COORD_W-1:0] point_y,
    input  logic signed [COORD_W-1:0] point_z,
    input  cfg_t                      cfg,
    output cell_t                     head
);

    logic                     m_valid_reg;
    logic                     m_behind_reg;
    logic [Z_W-1:0]           m_div_reg;
    logic signed [PROD_W-1:0] m_prod_u_reg;
    logic signed [PROD_W-1:0] m_prod_v_reg;

    logic                     a_valid_reg;
    logic                     a_behind_reg;
    logic [Z_W-1:0]           a_div_reg;
    logic                     a_neg_u_reg;
    logic                     a_neg_v_reg;
    logic [MAG_W-1:0]         a_mag_u_reg;
    logic [MAG_W-1:0]         a_mag_v_reg;

    logic                     head_valid_reg;
    cell_t                    head_reg;
    cell_t                    head_next;

    logic signed [PROD_W-1:0] prod_u;
    logic signed [PROD_W-1:0] prod_v;
    logic [PROD_W-1:0]        abs_u;
    logic [PROD_W-1:0]        abs_v;
    logic                     behind;

    function automatic lane_t lane_init(logic neg, logic [MAG_W-1:0] mag,
                                        logic [Z_W-1:0] div);
        logic [Z_W-1:0] high;
        lane_t          l;
        high  = {2'b00, mag[MAG_W-1:QUO_W]};
        l.neg = neg;
        l.ovf = (high >= div);
        l.rem = l.ovf ? '0 : high;
        l.acc = mag[QUO_W-1:0];
        return l;
    endfunction

    assign prod_u = $signed({1'b0, cfg.focal_x}) * point_x;
    assign prod_v = $signed({1'b0, cfg.focal_y}) * point_y;
    assign behind = point_z[COORD_W-1] | (point_z == '0);

    assign abs_u = m_prod_u_reg[PROD_W-1] ? PROD_W'(-m_prod_u_reg) : m_prod_u_reg;
    assign abs_v = m_prod_v_reg[PROD_W-1] ? PROD_W'(-m_prod_v_reg) : m_prod_v_reg;

    always_comb
    begin
        head_next.valid  = a_valid_reg;
        head_next.behind = a_behind_reg;
        head_next.div    = a_div_reg;
        head_next.u      = lane_init(a_neg_u_reg, a_mag_u_reg, a_div_reg);
        head_next.v      = lane_init(a_neg_v_reg, a_mag_v_reg, a_div_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg    <= 1'b0;
            a_valid_reg    <= 1'b0;
            head_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            m_valid_reg    <= in_valid;
            a_valid_reg    <= m_valid_reg;
            head_valid_reg <= head_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_behind_reg    <= behind;
            m_div_reg       <= point_z[Z_W-1:0];
            m_prod_u_reg    <= prod_u;
            m_prod_v_reg    <= prod_v;
            a_behind_reg    <= m_behind_reg;
            a_div_reg       <= m_div_reg;
            a_neg_u_reg     <= m_prod_u_reg[PROD_W-1];
            a_neg_v_reg     <= m_prod_v_reg[PROD_W-1];
            a_mag_u_reg     <= abs_u[MAG_W-1:0];
            a_mag_v_reg     <= abs_v[MAG_W-1:0];
            head_reg        <= head_next;
        end
    end

    always_comb
    begin
        head       = head_reg;
        head.valid = head_valid_reg;
    end

endmodule

// ===== rtl/core/ppft_cell.sv =====
// One cell of the divider chain: a restoring division step for both axes.
// Depends on ppft_pkg.
module ppft_cell import ppft_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  cell_t prev,
    output cell_t next
);

    logic  next_valid_reg;
    cell_t next_reg;
    cell_t step_next;

    function automatic lane_t lane_step(lane_t l, logic [Z_W-1:0] div);
        logic [Z_W:0] trial;
        logic [Z_W:0] diff;
        lane_t        r;
        trial = {l.rem, l.acc[QUO_W-1]};
        diff  = trial - {1'b0, div};
        r     = l;
        if (trial >= {1'b0, div})
        begin
            r.rem = diff[Z_W-1:0];
            r.acc = {l.acc[QUO_W-2:0], 1'b1};
        end
        else
        begin
            r.rem = trial[Z_W-1:0];
            r.acc = {l.acc[QUO_W-2:0], 1'b0};
        end
        return r;
    endfunction

    always_comb
    begin
        step_next   = prev;
        step_next.u = lane_step(prev.u, prev.div);
        step_next.v = lane_step(prev.v, prev.div);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            next_valid_reg <= step_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            next_reg <= step_next;
        end
    end

    always_comb
    begin
        next       = next_reg;
        next.valid = next_valid_reg;
    end

endmodule

// ===== rtl/core/ppft_back.sv =====
// Back end: floor correction, principal point offset, bounds test and saturation.
// Depends on ppft_pkg.
module ppft_back import ppft_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    en,
    input  cell_t   tail,
    input  cfg_t    cfg,
    output logic    res_valid,
    output result_t res
);

    typedef struct packed {
        logic signed [PIX_W-1:0] pix;
        logic                    clip;
    } axis_t;

    logic                    f1_valid_reg;
    logic                    f1_behind_reg;
    logic signed [Q_W-1:0]   f1_q_u_reg;
    logic signed [Q_W-1:0]   f1_q_v_reg;
    logic                    f1_ovf_u_reg;
    logic                    f1_ovf_v_reg;
    logic                    f1_neg_u_reg;
    logic                    f1_neg_v_reg;

    logic                    f2_valid_reg;
    logic                    f2_behind_reg;
    logic signed [U_W-1:0]   f2_u_reg;
    logic signed [U_W-1:0]   f2_v_reg;
    logic                    f2_ovf_u_reg;
    logic                    f2_ovf_v_reg;
    logic                    f2_neg_u_reg;
    logic                    f2_neg_v_reg;

    logic signed [LIM_W-1:0] lim_w_reg;
    logic signed [LIM_W-1:0] lim_h_reg;

    logic                    res_valid_reg;
    result_t                 res_reg;
    result_t                 res_next;

    logic signed [U_W-1:0]   u_sum;
    logic signed [U_W-1:0]   v_sum;
    logic signed [CMP_W-1:0] margin;
    logic signed [CMP_W-1:0] u_cmp;
    logic signed [CMP_W-1:0] v_cmp;
    logic                    view;
    axis_t                   ax_u;
    axis_t                   ax_v;

    function automatic logic signed [Q_W-1:0] floor_q(lane_t l);
        logic [Q_W-1:0] ext;
        logic [Q_W-1:0] r;
        ext = {2'b00, l.acc};
        if (l.neg)
        begin
            r = ~ext + Q_W'(l.rem == '0);
        end
        else
        begin
            r = ext;
        end
        return $signed(r);
    endfunction

    function automatic axis_t saturate(logic signed [U_W-1:0] u, logic ovf, logic neg);
        axis_t a;
        if (ovf)
        begin
            a.pix  = neg ? PIX_MIN : PIX_MAX;
            a.clip = 1'b1;
        end
        else if (u > U_W'(PIX_MAX))
        begin
            a.pix  = PIX_MAX;
            a.clip = 1'b1;
        end
        else if (u < U_W'(PIX_MIN))
        begin
            a.pix  = PIX_MIN;
            a.clip = 1'b1;
        end
        else
        begin
            a.pix  = u[PIX_W-1:0];
            a.clip = 1'b0;
        end
        return a;
    endfunction

    assign u_sum = U_W'(f1_q_u_reg) + $signed({6'b0, cfg.center_x});
    assign v_sum = U_W'(f1_q_v_reg) + $signed({6'b0, cfg.center_y});

    assign margin = $signed({7'b0, cfg.border_margin});
    assign u_cmp  = CMP_W'(f2_u_reg);
    assign v_cmp  = CMP_W'(f2_v_reg);
    assign view   = !f2_ovf_u_reg && !f2_ovf_v_reg
                    && (u_cmp >= margin) && (u_cmp < CMP_W'(lim_w_reg))
                    && (v_cmp >= margin) && (v_cmp < CMP_W'(lim_h_reg));
    assign ax_u   = saturate(f2_u_reg, f2_ovf_u_reg, f2_neg_u_reg);
    assign ax_v   = saturate(f2_v_reg, f2_ovf_v_reg, f2_neg_v_reg);

    always_comb
    begin
        if (f2_behind_reg)
        begin
            res_next.pixel_u = '0;
            res_next.pixel_v = '0;
            res_next.in_view = 1'b0;
            res_next.behind  = 1'b1;
            res_next.clipped = 1'b0;
        end
        else
        begin
            res_next.pixel_u = ax_u.pix;
            res_next.pixel_v = ax_v.pix;
            res_next.in_view = view;
            res_next.behind  = 1'b0;
            res_next.clipped = ax_u.clip | ax_v.clip;
        end
    end

    always_ff @(posedge clk)
    begin
        lim_w_reg <= $signed({2'b00, cfg.image_width, {FRAC_W{1'b0}}})
                     - $signed({3'b000, cfg.border_margin});
        lim_h_reg <= $signed({2'b00, cfg.image_height, {FRAC_W{1'b0}}})
                     - $signed({3'b000, cfg.border_margin});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg  <= 1'b0;
            f2_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            f1_valid_reg  <= tail.valid;
            f2_valid_reg  <= f1_valid_reg;
            res_valid_reg <= f2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_behind_reg <= tail.behind;
            f1_q_u_reg    <= floor_q(tail.u);
            f1_q_v_reg    <= floor_q(tail.v);
            f1_ovf_u_reg  <= tail.u.ovf;
            f1_ovf_v_reg  <= tail.v.ovf;
            f1_neg_u_reg  <= tail.u.neg;
            f1_neg_v_reg  <= tail.v.neg;
            f2_behind_reg <= f1_behind_reg;
            f2_u_reg      <= u_sum;
            f2_v_reg      <= v_sum;
            f2_ovf_u_reg  <= f1_ovf_u_reg;
            f2_ovf_v_reg  <= f1_ovf_v_reg;
            f2_neg_u_reg  <= f1_neg_u_reg;
            f2_neg_v_reg  <= f1_neg_v_reg;
            res_reg       <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ===== rtl/core/pinhole_project_frustum_test_unit.sv =====
// Pinhole camera projection with frustum test, top level of the block.
// Depends on ppft_pkg, ppft_point_if, ppft_pixel_if, ppft_front, ppft_cell and ppft_back.
//
// Points in signed Q16.16 camera coordinates arrive as transactions on the point
// channel; every point yields exactly one transaction on the pixel channel, in order.
// Each result carries the projected column and row in signed Q15.8, the in-view,
// behind and clipped flags. Intrinsics, image size and border margin must be written
// through the configuration port only while no point is in flight; the block itself
// does not enforce this. A point is accepted in every cycle that ready is high, so
// the sustained rate is one point per cycle. Its result passes through three front
// stages (multiply, magnitude, overflow pre-check), a chain of 25 division cells
// that each retire one quotient bit, and four back stages up to the output
// register.
// Reset clears every valid flag and loads the default camera configuration.
// When the receiver stalls, the output register holds its transaction and a skid
// register catches the next one; ready then drops and the whole pipeline freezes
// until the skid register drains.
module pinhole_project_frustum_test_unit import ppft_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    ppft_point_if.sink        point,
    ppft_pixel_if.source      pixel,
    input  logic              cfg_we,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]  cfg_data
);

    cfg_t    cfg_reg;
    cfg_t    cfg_next;

    logic    pipe_en;
    cell_t   chain [0:QUO_W];
    logic    res_valid;
    result_t res;

    logic    out_valid_reg;
    result_t out_reg;
    logic    skid_valid_reg;
    result_t skid_reg;
    logic    out_free;

    always_comb
    begin
        cfg_next = cfg_reg;
        case (cfg_reg_t'(cfg_index))
            REG_FOCAL_X:       cfg_next.focal_x       = cfg_data;
            REG_FOCAL_Y:       cfg_next.focal_y       = cfg_data;
            REG_CENTER_X:      cfg_next.center_x      = cfg_data;
            REG_CENTER_Y:      cfg_next.center_y      = cfg_data;
            REG_IMAGE_WIDTH:   cfg_next.image_width   = cfg_data[SIZE_W-1:0];
            REG_IMAGE_HEIGHT:  cfg_next.image_height  = cfg_data[SIZE_W-1:0];
            REG_BORDER_MARGIN: cfg_next.border_margin = cfg_data;
            default:           cfg_next = cfg_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign pipe_en     = !skid_valid_reg;
    assign point.ready = pipe_en;

    ppft_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (pipe_en),
        .in_valid (point.valid),
        .point_x  (point.point_x),
        .point_y  (point.point_y),
        .point_z  (point.point_z),
        .cfg      (cfg_reg),
        .head     (chain[0])
    );

    for (genvar i = 0; i < QUO_W; i++)
    begin : g_cell
        ppft_cell u_cell
        (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (pipe_en),
            .prev  (chain[i]),
            .next  (chain[i+1])
        );
    end

    ppft_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .tail      (chain[QUO_W]),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    assign out_free = !out_valid_reg || pixel.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_free)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (out_free)
        begin
            out_valid_reg <= res_valid;
        end
        else if (res_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_free)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (out_free)
        begin
            out_reg <= res;
        end
        else
        begin
            skid_reg <= res;
        end
    end

    assign pixel.valid   = out_valid_reg;
    assign pixel.pixel_u = out_reg.pixel_u;
    assign pixel.pixel_v = out_reg.pixel_v;
    assign pixel.in_view = out_reg.in_view;
    assign pixel.behind  = out_reg.behind;
    assign pixel.clipped = out_reg.clipped;

endmodule

// ===== sim/pinhole_project_frustum_test_unit_checker.sv =====
// Checker for the pinhole projection block: mirrors the configuration port, projects each
// accepted point and compares every pixel transaction against the oldest projection.
// Depends on ppft_pkg, ppft_point_if and ppft_pixel_if.
module pinhole_project_frustum_test_unit_checker import ppft_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    ppft_point_if             point,
    ppft_pixel_if             pixel,
    input  logic              cfg_we,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    output int                errors,
    output int                pending
);

    cfg_t    camera;
    result_t expected_pixels[$];
    int      pixel_count;

    function automatic longint project_axis(input logic [CFG_W-1:0] focal,
                                            input logic [CFG_W-1:0] center,
                                            input logic signed [COORD_W-1:0] coord,
                                            input logic signed [COORD_W-1:0] depth);
        longint f;
        longint c;
        longint n;
        longint d;
        longint q;
        f = focal;
        c = coord;
        d = depth;
        n = f * c;
        q = n / d;
        if ((n % d) != 0 && n < 0)
        begin
            q = q - 1;
        end
        c = center;
        return q + c;
    endfunction

    function automatic result_t project_point(input cfg_t cam,
                                              input logic signed [COORD_W-1:0] x,
                                              input logic signed [COORD_W-1:0] y,
                                              input logic signed [COORD_W-1:0] z);
        result_t r;
        longint  u;
        longint  v;
        longint  m;
        longint  wlim;
        longint  hlim;
        longint  hi;
        longint  lo;
        r = '0;
        if (z <= 0)
        begin
            r.behind = 1'b1;
            return r;
        end
        u = project_axis(cam.focal_x, cam.center_x, x, z);
        v = project_axis(cam.focal_y, cam.center_y, y, z);
        m = cam.border_margin;
        wlim = longint'(cam.image_width) * 256 - m;
        hlim = longint'(cam.image_height) * 256 - m;
        r.in_view = (u >= m) && (u < wlim) && (v >= m) && (v < hlim);
        hi = PIX_MAX;
        lo = PIX_MIN;
        if (u > hi || u < lo || v > hi || v < lo)
        begin
            r.clipped = 1'b1;
        end
        u = (u > hi) ? hi : ((u < lo) ? lo : u);
        v = (v > hi) ? hi : ((v < lo) ? lo : v);
        r.pixel_u = u[PIX_W-1:0];
        r.pixel_v = v[PIX_W-1:0];
        return r;
    endfunction

    task automatic report(input string msg);
        if (errors < 100)
        begin
            $display("ERROR: transaction %0d: %s", pixel_count, msg);
        end
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            camera <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FOCAL_X:       camera.focal_x <= cfg_data;
                REG_FOCAL_Y:       camera.focal_y <= cfg_data;
                REG_CENTER_X:      camera.center_x <= cfg_data;
                REG_CENTER_Y:      camera.center_y <= cfg_data;
                REG_IMAGE_WIDTH:   camera.image_width <= cfg_data[SIZE_W-1:0];
                REG_IMAGE_HEIGHT:  camera.image_height <= cfg_data[SIZE_W-1:0];
                REG_BORDER_MARGIN: camera.border_margin <= cfg_data;
                default:           ;
            endcase
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (pixel.valid && pixel.ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    report("pixel transaction with no point outstanding");
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (pixel.pixel_u !== want.pixel_u)
                        report($sformatf("pixel_u got %0d expected %0d",
                                         pixel.pixel_u, want.pixel_u));
                    if (pixel.pixel_v !== want.pixel_v)
                        report($sformatf("pixel_v got %0d expected %0d",
                                         pixel.pixel_v, want.pixel_v));
                    if (pixel.in_view !== want.in_view)
                        report($sformatf("in_view got %b expected %b",
                                         pixel.in_view, want.in_view));
                    if (pixel.behind !== want.behind)
                        report($sformatf("behind got %b expected %b",
                                         pixel.behind, want.behind));
                    if (pixel.clipped !== want.clipped)
                        report($sformatf("clipped got %b expected %b",
                                         pixel.clipped, want.clipped));
                end
                pixel_count++;
            end
            if (point.valid && point.ready)
            begin
                expected_pixels.push_back(project_point(camera, point.point_x,
                                                        point.point_y, point.point_z));
            end
        end
        pending = expected_pixels.size();
    end

endmodule

// ===== sim/pinhole_project_frustum_test_unit_test.sv =====
// Testbench top for the pinhole projection block: clock, reset, configuration phases,
// point stimulus with bursts and gaps, a stalling receiver and the final verdict.
// Depends on ppft_pkg, both channel interfaces, the block and its checker.
module pinhole_project_frustum_test_unit_test import ppft_pkg::*;;

    localparam logic [CIDX_W-1:0]         REG_NONE   = 3'd7;
    localparam logic signed [COORD_W-1:0] C_MAX      = 32'sh7FFFFFFF;
    localparam logic signed [COORD_W-1:0] C_MIN      = 32'sh80000000;
    localparam logic signed [COORD_W-1:0] ONE_METER  = 32'sd65536;
    localparam logic [CFG_W-1:0]          CFG_ALL    = 22'h3FFFFF;
    localparam int                        LIMIT      = 400000;
    localparam int                        LATENCY    = 40;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [CIDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]  cfg_data;
    int                errors;
    int                pending;
    int                burst_left;

    ppft_point_if point_ch();
    ppft_pixel_if pixel_ch();

    pinhole_project_frustum_test_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .point     (point_ch),
        .pixel     (pixel_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pinhole_project_frustum_test_unit_checker checker_i (
        .clk       (clk),
        .rst_n     (rst_n),
        .point     (point_ch),
        .pixel     (pixel_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    initial
    begin
        repeat (LIMIT) @(posedge clk);
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        int mode;
        int left;
        int tick;
        mode = 0;
        left = 0;
        tick = 0;
        pixel_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (left == 0)
            begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(20, 200);
            end
            left--;
            tick++;
            case (mode)
                0:       pixel_ch.ready <= 1'b1;
                1:       pixel_ch.ready <= ($urandom_range(0, 9) < 7);
                2:       pixel_ch.ready <= ((tick % 5) != 0);
                default: pixel_ch.ready <= ((tick % 32) < 8);
            endcase
        end
    end

    function automatic int pick_burst();
        if ($urandom_range(0, 4) == 0)
            return $urandom_range(200, 400);
        return $urandom_range(1, 40);
    endfunction

    task automatic send_point(input logic signed [COORD_W-1:0] x,
                              input logic signed [COORD_W-1:0] y,
                              input logic signed [COORD_W-1:0] z);
        point_ch.valid   <= 1'b1;
        point_ch.point_x <= x;
        point_ch.point_y <= y;
        point_ch.point_z <= z;
        @(posedge clk);
        while (!point_ch.ready) @(posedge clk);
        @(negedge clk);
        burst_left--;
        if (burst_left <= 0)
        begin
            point_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
            burst_left = pick_burst();
        end
    endtask

    task automatic send_random_point();
        int                         kind;
        int                         z;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [COORD_W-1:0] pz;
        kind = $urandom_range(0, 99);
        if (kind < 45)
        begin
            z = $urandom_range(4096, 8388608);
            px = $urandom_range(0, 2 * z) - z;
            py = $urandom_range(0, 2 * z) - z;
            pz = z;
        end
        else if (kind < 60)
        begin
            px = $urandom;
            py = $urandom;
            pz = $urandom;
        end
        else if (kind < 72)
        begin
            px = $urandom;
            py = $urandom;
            pz = ($urandom_range(0, 7) == 0) ? '0 : ($urandom | 32'h80000000);
        end
        else if (kind < 87)
        begin
            px = $urandom;
            py = $urandom;
            pz = $urandom_range(1, 300);
        end
        else
        begin
            px = $urandom_range(0, 8192) - 4096;
            py = $urandom_range(0, 8192) - 4096;
            pz = $urandom_range(1, 65536);
        end
        send_point(px, py, pz);
    endtask

    task automatic wait_idle();
        point_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    task automatic write_camera(input logic [CFG_W-1:0] vals [7]);
        cfg_reg_t r;
        r = r.first();
        repeat (7)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= r;
            cfg_data  <= vals[r];
            @(negedge clk);
            r = r.next();
        end
        cfg_index <= REG_NONE;
        cfg_data  <= CFG_W'($urandom);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        logic [CFG_W-1:0] vals [7];
        int               w;
        int               h;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = REG_FOCAL_X;
        cfg_data         = '0;
        point_ch.valid   = 1'b0;
        point_ch.point_x = '0;
        point_ch.point_y = '0;
        point_ch.point_z = '0;
        burst_left       = pick_burst();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_point(0, 0, ONE_METER);
        send_point(0, 0, 0);
        send_point(C_MAX, C_MAX, -1);
        send_point(C_MIN, C_MIN, C_MIN);
        send_point(C_MAX, C_MIN, 1);
        send_point(C_MIN, C_MAX, 1);
        send_point(C_MAX, C_MAX, C_MAX);
        send_point(C_MIN, C_MIN, C_MAX);
        send_point(-41943, -31457, ONE_METER);
        send_point(-41944, -31458, ONE_METER);
        send_point(41943, 31457, ONE_METER);
        send_point(41944, 31458, ONE_METER);
        send_point(-1, -1, 3);
        send_point(1, 1, 3);
        send_point(0, 0, 1);
        send_point(-1, 0, C_MAX);
        send_point(64, -64, 1);
        send_point(65, -65, 1);
        send_point(0, C_MAX, 2);
        send_point(C_MAX, 0, ONE_METER);
        repeat (100) send_random_point();

        for (int p = 1; p <= 9; p++)
        begin
            wait_idle();
            case (p)
                1:
                begin
                    foreach (vals[i]) vals[i] = CFG_ALL;
                end
                2:
                begin
                    foreach (vals[i]) vals[i] = '0;
                end
                3:
                begin
                    vals[REG_FOCAL_X]       = 22'd128000;
                    vals[REG_FOCAL_Y]       = 22'd128000;
                    vals[REG_CENTER_X]      = 22'd2097152;
                    vals[REG_CENTER_Y]      = 22'd2097152;
                    vals[REG_IMAGE_WIDTH]   = 22'd16384;
                    vals[REG_IMAGE_HEIGHT]  = 22'd16384;
                    vals[REG_BORDER_MARGIN] = 22'd256;
                end
                default:
                begin
                    w = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16384)
                                                    : $urandom_range(1, 4096);
                    h = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16384)
                                                    : $urandom_range(1, 4096);
                    vals[REG_FOCAL_X]       = CFG_W'($urandom_range(0, 512000));
                    vals[REG_FOCAL_Y]       = CFG_W'($urandom_range(0, 512000));
                    vals[REG_CENTER_X]      = CFG_W'($urandom_range(0, w * 256));
                    vals[REG_CENTER_Y]      = CFG_W'($urandom_range(0, h * 256));
                    vals[REG_IMAGE_WIDTH]   = CFG_W'(w);
                    vals[REG_IMAGE_HEIGHT]  = CFG_W'(h);
                    vals[REG_BORDER_MARGIN] = CFG_W'($urandom_range(0, w * 32));
                end
            endcase
            write_camera(vals);
            repeat (135) send_random_point();
        end

        wait_idle();
        repeat (LATENCY) @(negedge clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
